[sv/sas_pkg.sv]
`timescale 1ns / 1ps

package sas_pkg;

    // Field widths
    localparam int ANIM_W   = 4;
    localparam int START_W  = 10;
    localparam int SIZE_W   = 10;
    localparam int DELAY_W  = 32;
    localparam int TIME_W   = 33;
    localparam int FRAME_W  = 11;
    localparam int COORD_W  = 20;
    localparam int FDIM_W   = 10;
    localparam int FPR_W    = 11;
    localparam int ACOUNT_W = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_COUNT     = 2'd3;

    localparam logic [FDIM_W-1:0]   FRAME_WIDTH_RST    = 10'd16;
    localparam logic [FDIM_W-1:0]   FRAME_HEIGHT_RST   = 10'd16;
    localparam logic [FPR_W-1:0]    FRAMES_PER_ROW_RST = 11'd1;
    localparam logic [ACOUNT_W-1:0] ANIM_COUNT_RST     = 5'd1;

    // Request function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SELECT = 2'd1;
    localparam logic [1:0] FUNC_WRITE  = 2'd2;

    // Table depth default
    localparam int MAX_ANIMS_DEF = 16;

    // Shared divider: step counts for the time and coordinate divisions
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_TIME  = 6'd33;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FRAME = 6'd11;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic [DELAY_W-1:0] delay;
    } anim_entry_t;

endpackage

[sv/sprite_animation_sequencer.sv]
`timescale 1ns / 1ps
// Write or unused request: sheet coordinates only. Select: table read, start frame,
// coordinates. Tick: table read, time division once the delay has passed, then
// advance or revert, coordinates. One shared restoring divider (one quotient bit per
// cycle) does both: 33 steps for the elapsed-time division, 11 for the sheet coordinates.
// Requests are taken one at a time; the next is taken while a result waits.
// Reset (aresetn low at aclk): registers to defaults, animation 0, frame 0, time 0.

module sprite_animation_sequencer #(
    parameter int MAX_ANIMS = sas_pkg::MAX_ANIMS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [sas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sas_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_func,
    input  logic [sas_pkg::DELAY_W-1:0]          s_time_step,
    input  logic [sas_pkg::ANIM_W-1:0]           s_anim_index,
    input  logic                                 s_make_default,
    input  logic [sas_pkg::START_W-1:0]          s_entry_start,
    input  logic [sas_pkg::SIZE_W-1:0]           s_entry_size,
    input  logic [sas_pkg::DELAY_W-1:0]          s_entry_delay,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sas_pkg::ANIM_W-1:0]           m_current_anim,
    output logic [sas_pkg::FRAME_W-1:0]          m_current_frame,
    output logic [sas_pkg::COORD_W-1:0]          m_source_x,
    output logic [sas_pkg::COORD_W-1:0]          m_source_y,
    output logic                                 m_reverted
);

    localparam int AW = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
    localparam int IW = (AW > sas_pkg::ANIM_W) ? AW : sas_pkg::ANIM_W;
    localparam int SHIFT_W = sas_pkg::TIME_W - sas_pkg::FRAME_W;
    localparam int XPROD_W = sas_pkg::FDIM_W + sas_pkg::FRAME_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRD   = 3'd1;
    localparam logic [2:0] S_DIVT  = 3'd2;
    localparam logic [2:0] S_TFIN  = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_COORD = 3'd5;
    localparam logic [2:0] S_DIVC  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // Out-of-range index falls back to animation 0
    function automatic logic [sas_pkg::ANIM_W-1:0] clamp_idx(
        input logic [sas_pkg::ANIM_W-1:0]   idx,
        input logic [sas_pkg::ACOUNT_W-1:0] cnt
    );
        logic [sas_pkg::ANIM_W-1:0] res;
        res = idx;
        if ({1'b0, idx} >= cnt || 32'(idx) >= MAX_ANIMS) begin
            res = '0;
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [sas_pkg::ANIM_W-1:0] idx);
        logic [IW-1:0] wide;
        wide = IW'(idx);
        return wide[AW-1:0];
    endfunction

    // Configuration registers
    logic [sas_pkg::FDIM_W-1:0]   frame_width_reg;
    logic [sas_pkg::FDIM_W-1:0]   frame_height_reg;
    logic [sas_pkg::FPR_W-1:0]    frames_per_row_reg;
    logic [sas_pkg::ACOUNT_W-1:0] anim_count_reg;

    // Animation state
    logic [2:0]                   state_reg, state_next;
    logic [sas_pkg::ANIM_W-1:0]   playing_reg, playing_next;
    logic [sas_pkg::ANIM_W-1:0]   fallback_reg, fallback_next;
    logic [sas_pkg::FRAME_W-1:0]  frame_reg, frame_next;
    logic [sas_pkg::TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [sas_pkg::FRAME_W-1:0]  left_reg, left_next;
    logic                         rev_reg, rev_next;

    // Shared divider
    logic [sas_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [sas_pkg::DELAY_W-1:0]   div_rem_reg, div_rem_next;
    logic [sas_pkg::TIME_W-1:0]    div_dvd_reg, div_dvd_next;
    logic [sas_pkg::DELAY_W-1:0]   div_den_reg, div_den_next;

    // Result register
    logic                          m_valid_reg, m_valid_next;
    logic [sas_pkg::ANIM_W-1:0]    m_anim_reg, m_anim_next;
    logic [sas_pkg::FRAME_W-1:0]   m_frame_reg, m_frame_next;
    logic [sas_pkg::COORD_W-1:0]   m_x_reg, m_x_next;
    logic [sas_pkg::COORD_W-1:0]   m_y_reg, m_y_next;
    logic                          m_rev_reg, m_rev_next;

    // Animation table
    sas_pkg::anim_entry_t anim_mem [MAX_ANIMS];
    sas_pkg::anim_entry_t rd_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;

    logic                         accept;
    logic [sas_pkg::ANIM_W-1:0]   sel_idx;
    logic [sas_pkg::ANIM_W-1:0]   play_idx;
    logic [sas_pkg::ANIM_W-1:0]   fall_idx;
    logic [sas_pkg::DELAY_W-1:0]  delay_eff;
    logic [sas_pkg::FRAME_W-1:0]  end_frame;
    logic [sas_pkg::FPR_W-1:0]    fpr_eff;
    logic [sas_pkg::TIME_W-1:0]   trial;
    logic [sas_pkg::TIME_W-1:0]   diff;
    logic                         fits;
    logic [sas_pkg::DELAY_W-1:0]  step_rem;
    logic [sas_pkg::TIME_W-1:0]   step_dvd;
    logic                         k_small;
    logic [XPROD_W-1:0]           x_prod;
    logic [XPROD_W-1:0]           y_prod;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign sel_idx  = clamp_idx(s_anim_index, anim_count_reg);
    assign play_idx = clamp_idx(playing_reg, anim_count_reg);
    assign fall_idx = clamp_idx(fallback_reg, anim_count_reg);

    assign wr_en   = accept && (s_func == sas_pkg::FUNC_WRITE) && (32'(s_anim_index) < MAX_ANIMS);
    assign wr_addr = to_addr(s_anim_index);

    // Zero delay and zero frames per row count as one
    assign delay_eff = (rd_reg.delay == '0) ? sas_pkg::DELAY_W'(1) : rd_reg.delay;
    assign fpr_eff   = (frames_per_row_reg == '0) ? sas_pkg::FPR_W'(1) : frames_per_row_reg;
    assign end_frame = sas_pkg::FRAME_W'(rd_reg.start) + sas_pkg::FRAME_W'(rd_reg.size);

    // One restoring divide step
    assign trial    = {div_rem_reg, div_dvd_reg[sas_pkg::TIME_W-1]};
    assign fits     = trial >= {1'b0, div_den_reg};
    assign diff     = trial - {1'b0, div_den_reg};
    assign step_rem = fits ? diff[sas_pkg::DELAY_W-1:0] : trial[sas_pkg::DELAY_W-1:0];
    assign step_dvd = {div_dvd_reg[sas_pkg::TIME_W-2:0], fits};

    // Quotient of the time division fits the frames left
    assign k_small = (div_dvd_reg[sas_pkg::TIME_W-1:sas_pkg::FRAME_W] == '0) &&
                     (div_dvd_reg[sas_pkg::FRAME_W-1:0] < left_reg);

    // Sheet coordinates from remainder and quotient
    assign x_prod = XPROD_W'(frame_width_reg) * XPROD_W'(div_rem_reg[sas_pkg::FRAME_W-1:0]);
    assign y_prod = XPROD_W'(frame_height_reg) * XPROD_W'(div_dvd_reg[sas_pkg::FRAME_W-1:0]);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        playing_next  = playing_reg;
        fallback_next = fallback_reg;
        frame_next    = frame_reg;
        elapsed_next  = elapsed_reg;
        left_next     = left_reg;
        rev_next      = rev_reg;
        div_cnt_next  = div_cnt_reg;
        div_rem_next  = div_rem_reg;
        div_dvd_next  = div_dvd_reg;
        div_den_next  = div_den_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_anim_next   = m_anim_reg;
        m_frame_next  = m_frame_reg;
        m_x_next      = m_x_reg;
        m_y_next      = m_y_reg;
        m_rev_next    = m_rev_reg;
        rd_en         = 1'b0;
        rd_addr       = to_addr(play_idx);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    rev_next = 1'b0;
                    unique case (s_func)
                        sas_pkg::FUNC_TICK: begin
                            elapsed_next = elapsed_reg + sas_pkg::TIME_W'(s_time_step);
                            rd_en        = 1'b1;
                            rd_addr      = to_addr(play_idx);
                            state_next   = S_TRD;
                        end
                        sas_pkg::FUNC_SELECT: begin
                            playing_next = sel_idx;
                            if (s_make_default) begin
                                fallback_next = sel_idx;
                            end
                            elapsed_next = '0;
                            rd_en        = 1'b1;
                            rd_addr      = to_addr(sel_idx);
                            state_next   = S_LOAD;
                        end
                        default: begin
                            state_next = S_COORD;
                        end
                    endcase
                end
            end
            // Entry read back: check whether the delay has passed
            S_TRD: begin
                left_next = (end_frame > frame_reg) ? (end_frame - frame_reg)
                                                    : sas_pkg::FRAME_W'(1);
                if (elapsed_reg <= sas_pkg::TIME_W'(delay_eff)) begin
                    state_next = S_COORD;
                end else begin
                    div_dvd_next = elapsed_reg - sas_pkg::TIME_W'(1);
                    div_den_next = delay_eff;
                    div_rem_next = '0;
                    div_cnt_next = sas_pkg::DIV_STEPS_TIME;
                    state_next   = S_DIVT;
                end
            end
            S_DIVT: begin
                div_rem_next = step_rem;
                div_dvd_next = step_dvd;
                div_cnt_next = div_cnt_reg - sas_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == sas_pkg::DIV_CNT_W'(1)) begin
                    state_next = S_TFIN;
                end
            end
            // Advance by the quotient, keep remainder plus one, or revert
            S_TFIN: begin
                if (k_small) begin
                    frame_next   = frame_reg + div_dvd_reg[sas_pkg::FRAME_W-1:0];
                    elapsed_next = sas_pkg::TIME_W'(div_rem_reg) + sas_pkg::TIME_W'(1);
                    state_next   = S_COORD;
                end else begin
                    playing_next = fall_idx;
                    elapsed_next = '0;
                    rev_next     = 1'b1;
                    rd_en        = 1'b1;
                    rd_addr      = to_addr(fall_idx);
                    state_next   = S_LOAD;
                end
            end
            S_LOAD: begin
                frame_next = sas_pkg::FRAME_W'(rd_reg.start);
                state_next = S_COORD;
            end
            // Frame divided by frames per row
            S_COORD: begin
                div_dvd_next = {frame_reg, SHIFT_W'(0)};
                div_den_next = sas_pkg::DELAY_W'(fpr_eff);
                div_rem_next = '0;
                div_cnt_next = sas_pkg::DIV_STEPS_FRAME;
                state_next   = S_DIVC;
            end
            S_DIVC: begin
                div_rem_next = step_rem;
                div_dvd_next = step_dvd;
                div_cnt_next = div_cnt_reg - sas_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == sas_pkg::DIV_CNT_W'(1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_anim_next  = playing_reg;
                    m_frame_next = frame_reg;
                    m_x_next     = x_prod[sas_pkg::COORD_W-1:0];
                    m_y_next     = y_prod[sas_pkg::COORD_W-1:0];
                    m_rev_next   = rev_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            playing_reg        <= '0;
            fallback_reg       <= '0;
            frame_reg          <= '0;
            elapsed_reg        <= '0;
            m_valid_reg        <= 1'b0;
            frame_width_reg    <= sas_pkg::FRAME_WIDTH_RST;
            frame_height_reg   <= sas_pkg::FRAME_HEIGHT_RST;
            frames_per_row_reg <= sas_pkg::FRAMES_PER_ROW_RST;
            anim_count_reg     <= sas_pkg::ANIM_COUNT_RST;
        end else begin
            state_reg    <= state_next;
            playing_reg  <= playing_next;
            fallback_reg <= fallback_next;
            frame_reg    <= frame_next;
            elapsed_reg  <= elapsed_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    sas_pkg::CFG_FRAME_WIDTH: begin
                        frame_width_reg <= cfg_data[sas_pkg::FDIM_W-1:0];
                    end
                    sas_pkg::CFG_FRAME_HEIGHT: begin
                        frame_height_reg <= cfg_data[sas_pkg::FDIM_W-1:0];
                    end
                    sas_pkg::CFG_FRAMES_PER_ROW: begin
                        frames_per_row_reg <= cfg_data[sas_pkg::FPR_W-1:0];
                    end
                    sas_pkg::CFG_ANIM_COUNT: begin
                        anim_count_reg <= cfg_data[sas_pkg::ACOUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        left_reg    <= left_next;
        rev_reg     <= rev_next;
        div_cnt_reg <= div_cnt_next;
        div_rem_reg <= div_rem_next;
        div_dvd_reg <= div_dvd_next;
        div_den_reg <= div_den_next;
        m_anim_reg  <= m_anim_next;
        m_frame_reg <= m_frame_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_rev_reg   <= m_rev_next;
    end

    // Animation table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            anim_mem[wr_addr] <= '{start: s_entry_start, size: s_entry_size,
                                   delay: s_entry_delay};
        end
        if (rd_en) begin
            rd_reg <= anim_mem[rd_addr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_current_anim  = m_anim_reg;
    assign m_current_frame = m_frame_reg;
    assign m_source_x      = m_x_reg;
    assign m_source_y      = m_y_reg;
    assign m_reverted      = m_rev_reg;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // Func code the block leaves unused: it must report state and change nothing
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 8000;
    localparam int PHASE_REQUESTS = 255;

    typedef struct {
        logic [1:0]                  func;
        logic [sas_pkg::DELAY_W-1:0] time_step;
        logic [sas_pkg::ANIM_W-1:0]  anim_index;
        logic                        make_default;
        logic [sas_pkg::START_W-1:0] entry_start;
        logic [sas_pkg::SIZE_W-1:0]  entry_size;
        logic [sas_pkg::DELAY_W-1:0] entry_delay;
    } sprite_req_t;

    typedef struct {
        logic [sas_pkg::ANIM_W-1:0]  anim;
        logic [sas_pkg::FRAME_W-1:0] frame;
        logic [sas_pkg::COORD_W-1:0] src_x;
        logic [sas_pkg::COORD_W-1:0] src_y;
        logic                        reverted;
    } sprite_view_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [sas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sas_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_func = FUNC_UNUSED;
    logic [sas_pkg::DELAY_W-1:0]    s_time_step = '0;
    logic [sas_pkg::ANIM_W-1:0]     s_anim_index = '0;
    logic                           s_make_default = 1'b0;
    logic [sas_pkg::START_W-1:0]    s_entry_start = '0;
    logic [sas_pkg::SIZE_W-1:0]     s_entry_size = '0;
    logic [sas_pkg::DELAY_W-1:0]    s_entry_delay = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [sas_pkg::ANIM_W-1:0]     m_current_anim;
    logic [sas_pkg::FRAME_W-1:0]    m_current_frame;
    logic [sas_pkg::COORD_W-1:0]    m_source_x;
    logic [sas_pkg::COORD_W-1:0]    m_source_y;
    logic                           m_reverted;

    sprite_animation_sequencer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_time_step     (s_time_step),
        .s_anim_index    (s_anim_index),
        .s_make_default  (s_make_default),
        .s_entry_start   (s_entry_start),
        .s_entry_size    (s_entry_size),
        .s_entry_delay   (s_entry_delay),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_anim  (m_current_anim),
        .m_current_frame (m_current_frame),
        .m_source_x      (m_source_x),
        .m_source_y      (m_source_y),
        .m_reverted      (m_reverted)
    );

    always #4 aclk = ~aclk;

    // Sheet model: animation table, playback state and register copies
    sas_pkg::anim_entry_t         anim_book [16];
    logic [sas_pkg::ANIM_W-1:0]   play_anim = '0;
    logic [sas_pkg::ANIM_W-1:0]   home_anim = '0;
    logic [sas_pkg::FRAME_W-1:0]  play_frame = '0;
    logic [sas_pkg::TIME_W-1:0]   play_time = '0;
    logic [sas_pkg::FDIM_W-1:0]   sheet_w = sas_pkg::FRAME_WIDTH_RST;
    logic [sas_pkg::FDIM_W-1:0]   sheet_h = sas_pkg::FRAME_HEIGHT_RST;
    logic [sas_pkg::FPR_W-1:0]    sheet_cols = sas_pkg::FRAMES_PER_ROW_RST;
    logic [sas_pkg::ACOUNT_W-1:0] anims_live = sas_pkg::ANIM_COUNT_RST;

    // Stimulus side bookkeeping: which entries hold data, count in force
    logic [15:0]                  entry_loaded = '0;
    logic [sas_pkg::ACOUNT_W-1:0] gen_live = sas_pkg::ANIM_COUNT_RST;

    sprite_req_t  requests_to_send [$];
    sprite_view_t views_due [$];
    sprite_req_t  req_on_bus;
    int requests_queued = 0;
    int requests_taken = 0;
    int views_seen = 0;
    int mismatch_count = 0;
    int send_gap = 0;
    int rx_hold = 0;
    int quiet_cycles = 0;

    function automatic logic [sas_pkg::ANIM_W-1:0] live_anim(
        input logic [sas_pkg::ANIM_W-1:0] idx
    );
        if ({1'b0, idx} >= anims_live) return '0;
        return idx;
    endfunction

    function automatic void jump_to_anim(input logic [sas_pkg::ANIM_W-1:0] idx, input logic mk);
        logic [sas_pkg::ANIM_W-1:0] a;
        a = live_anim(idx);
        play_anim = a;
        if (mk) home_anim = a;
        play_frame = {1'b0, anim_book[a].start};
        play_time = '0;
    endfunction

    // Add time, step frames; returns 1 when playback fell back to the default
    function automatic logic advance_time(input logic [sas_pkg::DELAY_W-1:0] dt);
        sas_pkg::anim_entry_t e;
        logic [63:0] d, k, last, left, el;
        play_time = play_time + {1'b0, dt};
        e = anim_book[live_anim(play_anim)];
        d = (e.delay == '0) ? 64'd1 : 64'(e.delay);
        el = 64'(play_time);
        if (el <= d) return 1'b0;
        k = (el - 64'd1) / d;
        last = 64'(e.start) + 64'(e.size);
        left = (last > 64'(play_frame)) ? last - 64'(play_frame) : 64'd1;
        if (k < left) begin
            play_frame = play_frame + k[sas_pkg::FRAME_W-1:0];
            play_time = play_time - k[sas_pkg::TIME_W-1:0] * d[sas_pkg::TIME_W-1:0];
            return 1'b0;
        end
        jump_to_anim(home_anim, 1'b0);
        return 1'b1;
    endfunction

    function automatic sprite_view_t next_sprite_view(input sprite_req_t r);
        sprite_view_t v;
        int unsigned cols, fr;
        v.reverted = 1'b0;
        case (r.func)
            sas_pkg::FUNC_TICK:   v.reverted = advance_time(r.time_step);
            sas_pkg::FUNC_SELECT: jump_to_anim(r.anim_index, r.make_default);
            sas_pkg::FUNC_WRITE:
                anim_book[r.anim_index] = {r.entry_start, r.entry_size, r.entry_delay};
            default: ;
        endcase
        cols = (sheet_cols == '0) ? 32'd1 : 32'(sheet_cols);
        fr = 32'(play_frame);
        v.anim = play_anim;
        v.frame = play_frame;
        v.src_x = sas_pkg::COORD_W'(32'(sheet_w) * (fr % cols));
        v.src_y = sas_pkg::COORD_W'(32'(sheet_h) * (fr / cols));
        return v;
    endfunction

    // Mostly short gaps, a few long, and no gaps for the first 48 of every 256 requests
    function automatic int idle_cycles_for(input int n);
        int roll;
        if ((n % 256) < 48) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic [1:0] func,
                                 input logic [sas_pkg::DELAY_W-1:0] dt,
                                 input logic [sas_pkg::ANIM_W-1:0] idx, input logic mk,
                                 input logic [sas_pkg::START_W-1:0] st,
                                 input logic [sas_pkg::SIZE_W-1:0] sz,
                                 input logic [sas_pkg::DELAY_W-1:0] dl);
        sprite_req_t r;
        r = '{func, dt, idx, mk, st, sz, dl};
        if (func == sas_pkg::FUNC_WRITE) entry_loaded[idx] = 1'b1;
        requests_to_send.push_back(r);
        requests_queued++;
    endtask

    // Random request: small sizes and delays near the tick size so frames
    // advance and wrap to the default often; full-range values now and then
    task automatic queue_random_request();
        int roll;
        logic [1:0]                  func;
        logic [sas_pkg::DELAY_W-1:0] dt, dl;
        logic [sas_pkg::ANIM_W-1:0]  idx;
        logic [sas_pkg::SIZE_W-1:0]  sz;
        dt = $urandom;
        dl = $urandom;
        idx = sas_pkg::ANIM_W'($urandom_range(0, 15));
        sz = sas_pkg::SIZE_W'($urandom_range(0, 1023));
        roll = $urandom_range(0, 99);
        if (roll < 4) func = FUNC_UNUSED;
        else if (roll < 22) func = sas_pkg::FUNC_WRITE;
        else if (roll < 38) func = sas_pkg::FUNC_SELECT;
        else func = sas_pkg::FUNC_TICK;
        case (func)
            sas_pkg::FUNC_WRITE: begin
                roll = $urandom_range(0, 99);
                if (roll < 10) sz = '0;
                else if (roll < 80) sz = sas_pkg::SIZE_W'($urandom_range(1, 8));
                roll = $urandom_range(0, 99);
                if (roll < 8) dl = '0;
                else if (roll < 18) dl = $urandom_range(1, 16);
                else if (roll < 88) dl = $urandom_range(32'h4000, 32'h20000);
            end
            sas_pkg::FUNC_SELECT: begin
                // never land on an entry that holds no data yet
                while ({1'b0, idx} < gen_live && !entry_loaded[idx])
                    idx = sas_pkg::ANIM_W'($urandom_range(0, 15));
            end
            sas_pkg::FUNC_TICK: begin
                roll = $urandom_range(0, 99);
                if (roll < 8) dt = '0;
                else if (roll < 18) dt = $urandom_range(0, 32);
                else if (roll < 88) dt = $urandom_range(0, 32'h30000);
            end
            default: ;
        endcase
        queue_request(func, dt, idx, 1'($urandom_range(0, 1)),
                      sas_pkg::START_W'($urandom_range(0, 1023)), sz, dl);
    endtask

    // Wait until every request is in and every frame report is back
    task automatic drain();
        do @(negedge aclk);
        while (requests_taken != requests_queued || views_due.size() != 0);
    endtask

    task automatic write_reg(input logic [sas_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[sas_pkg::CFG_DATA_W-1:0];
        case (idx)
            sas_pkg::CFG_FRAME_WIDTH:    sheet_w = val[sas_pkg::FDIM_W-1:0];
            sas_pkg::CFG_FRAME_HEIGHT:   sheet_h = val[sas_pkg::FDIM_W-1:0];
            sas_pkg::CFG_FRAMES_PER_ROW: sheet_cols = val[sas_pkg::FPR_W-1:0];
            default: begin
                anims_live = val[sas_pkg::ACOUNT_W-1:0];
                gen_live = val[sas_pkg::ACOUNT_W-1:0];
            end
        endcase
    endtask

    task automatic set_sheet(input int unsigned w, input int unsigned h,
                             input int unsigned cols, input int unsigned count);
        write_reg(sas_pkg::CFG_FRAME_WIDTH, w);
        write_reg(sas_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(sas_pkg::CFG_FRAMES_PER_ROW, cols);
        write_reg(sas_pkg::CFG_ANIM_COUNT, count);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                views_due.push_back(next_sprite_view(req_on_bus));
                requests_taken++;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (requests_to_send.size() != 0) begin
                    req_on_bus = requests_to_send.pop_front();
                    s_func <= req_on_bus.func;
                    s_time_step <= req_on_bus.time_step;
                    s_anim_index <= req_on_bus.anim_index;
                    s_make_default <= req_on_bus.make_default;
                    s_entry_start <= req_on_bus.entry_start;
                    s_entry_size <= req_on_bus.entry_size;
                    s_entry_delay <= req_on_bus.entry_delay;
                    s_valid <= 1'b1;
                    send_gap = idle_cycles_for(requests_taken);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge aclk) begin
        sprite_view_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (views_due.size() == 0) begin
                    report_mismatch("unrequested result, frame", 32'(m_current_frame), 32'd0);
                end else begin
                    want = views_due.pop_front();
                    if (m_current_anim !== want.anim)
                        report_mismatch("current_anim", 32'(m_current_anim), 32'(want.anim));
                    if (m_current_frame !== want.frame)
                        report_mismatch("current_frame", 32'(m_current_frame),
                                        32'(want.frame));
                    if (m_source_x !== want.src_x)
                        report_mismatch("source_x", 32'(m_source_x), 32'(want.src_x));
                    if (m_source_y !== want.src_y)
                        report_mismatch("source_y", 32'(m_source_y), 32'(want.src_y));
                    if (m_reverted !== want.reverted)
                        report_mismatch("reverted", 32'(m_reverted), 32'(want.reverted));
                end
                views_seen++;
                // long hold-off so the block backs up and stalls its input
                if (views_seen == 200 || views_seen == 1000) rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else begin
                rx_hold = idle_cycles_for(views_seen);
                m_ready <= (rx_hold == 0);
            end
        end
    end

    // Watchdog: no request or result moving for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // Reset register values, a single animation
        queue_request(FUNC_UNUSED, '1, 4'hF, 1'b1, '1, '1, '1);
        queue_request(sas_pkg::FUNC_WRITE, '0, 4'd0, 1'b0, 10'd5, 10'd3, 32'h10000);
        queue_request(sas_pkg::FUNC_WRITE, '0, 4'd15, 1'b1, 10'd1023, 10'd1023, 32'hFFFFFFFF);
        queue_request(sas_pkg::FUNC_WRITE, '1, 4'd1, 1'b0, 10'd0, 10'd0, 32'd0);
        // index past the count falls back to animation 0
        queue_request(sas_pkg::FUNC_SELECT, '0, 4'd15, 1'b1, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'd0, '0, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'h10000, '0, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'd1, '0, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'h20000, '0, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'hFFFFFFFF, '0, 1'b0, '0, '0, '0);
        // rewrite the playing entry so the frame sits past its end, zero delay
        queue_request(sas_pkg::FUNC_WRITE, '0, 4'd0, 1'b0, 10'd0, 10'd2, 32'd0);
        queue_request(sas_pkg::FUNC_TICK, 32'd2, '0, 1'b0, '0, '0, '0);
        queue_request(FUNC_UNUSED, '0, '0, 1'b0, '0, '0, '0);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        drain();

        // Wide sheet, full table
        set_sheet(512, 512, 1024, 16);
        queue_request(sas_pkg::FUNC_WRITE, '0, 4'd2, 1'b0, 10'd1000, 10'd40, 32'd3);
        queue_request(sas_pkg::FUNC_SELECT, '0, 4'd2, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'd100, '0, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_SELECT, '0, 4'd15, 1'b1, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'hFFFFFFFF, '0, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'hFFFFFFFF, '0, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_SELECT, '0, 4'd1, 1'b0, '0, '0, '0);
        queue_request(sas_pkg::FUNC_TICK, 32'd5, '0, 1'b0, '0, '0, '0);
        queue_request(FUNC_UNUSED, '0, '0, 1'b1, '0, '0, '0);
        drain();

        // Random traffic over several sheet layouts
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ;
                1: set_sheet(1, 1, 1, 16);
                2: set_sheet(37, 23, 0, 5);
                3: set_sheet(512, 1, 7, 1);
                default: set_sheet($urandom_range(1, 512), $urandom_range(1, 512),
                                   $urandom_range(1, 16), $urandom_range(1, 16));
            endcase
            repeat (PHASE_REQUESTS) queue_random_request();
            drain();
        end

        repeat (80) @(posedge aclk);
        if (views_due.size() != 0)
            report_mismatch("missing results", 32'(views_due.size()), 32'd0);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
